>>> hw/rtl/assert_macros.svh
// Assertion helpers; each use expects clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define JPE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");
`define JPE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define JPE_ASSERT_IMPLY(lbl, ante, cons)
`define JPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/jpe_pkg.sv
package jpe_pkg;

   localparam int MaxOrderDefault = 32;
   localparam int NumCells = 8;
   localparam int DivSteps = 96;
   localparam int DivCntW = $clog2(DivSteps + 2);
   localparam int CoefW = 24;
   localparam int Q8One = 256;
   localparam logic signed [63:0] ValMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] OneQ24 = 64'sh0000_0000_0100_0000;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusRange = 2'd1;
   localparam logic [1:0] StatusSat = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P1A,
      ST_P1B,
      ST_CHECK,
      ST_COEF0,
      ST_COEF1,
      ST_COEF2,
      ST_MULX,
      ST_MULX_W,
      ST_NUM,
      ST_DIV,
      ST_MULC1,
      ST_MULC1_W,
      ST_MULC2,
      ST_MULC2_W,
      ST_UPDATE,
      ST_DERIV,
      ST_DERIV_W,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [64:0] rem;
      logic [DivSteps-1:0] dq;
   } div_word_type;

   typedef struct packed {
      logic start;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic neg;
      logic [127:0] mag;
   } mul_rsp_type;

   typedef struct packed {
      logic sat;
      logic signed [63:0] val;
   } sat_val_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      logic [63:0] r;
      r = v[63] ? 64'(-v) : 64'(v);
      return r;
   endfunction

endpackage

>>> hw/rtl/jacobi_polynomial_eval.sv
// channel  | handshake                       | payload
// request  | start in, busy out              | req_op, req_order, req_point
// result   | rsp_valid out, one cycle        | rsp_value, rsp_status
// config   | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
// One request at a time; busy stays high until its result strobe.
// Degree m (order, or order-1 for a derivative) takes max(m-1,0) recurrence steps;
// a derivative adds a final multiply. An out-of-range request and a derivative of
// order 0 answer without a recurrence step. A recurrence step runs two interleaved
// 96-step quotients in the 8-cell divider ring and three multiplies through the
// 4-pass 32x32 multiplier.
// Reset is synchronous; it clears alpha and beta to zero and aborts work.
// The result is never held off: it shows for exactly one cycle.
module jacobi_polynomial_eval #(
   parameter int MaxOrder = jpe_pkg::MaxOrderDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [5:0]         req_order,
   input  logic signed [31:0] req_point,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_value,
   output logic [1:0]         rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import jpe_pkg::*;

`include "assert_macros.svh"

   localparam int NW = $clog2(MaxOrder + 1);
   localparam logic signed [64:0] Lim = 65'(ValMax);

   state_type state_ff, state_in;
   logic signed [12:0] alpha_ff, beta_ff;
   logic sat_ff, sat_in, err_ff, err_in, rsp_valid_ff, rsp_valid_in;
   logic [DivCntW-1:0] div_cnt_ff, div_cnt_in;
   logic signed [63:0] rsp_value_ff;
   logic [1:0] rsp_status_ff;

   logic op_ff;
   logic [NW-1:0] ne_ff, i_ff, n_sel;
   logic signed [31:0] x_ff;
   logic signed [15:0] am_ff, bm_ff, s_ff;
   logic signed [48:0] prod_ff;
   logic signed [31:0] asq_ff, bsq_ff, d_ff;
   logic signed [63:0] p0_ff, p1_ff, res_ff;
   logic signed [CoefW-1:0] t0_ff, t1_ff, t2_ff, u_ff, v1_ff, v2_ff, i1_ff;
   logic signed [31:0] m1_ff, m2_ff, m3_ff;
   logic signed [63:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [63:0] rx_ff, num_ff, r1_ff, r2_ff, c1_ff, c2_ff;
   logic neg1_ff, neg2_ff;
   logic [63:0] den_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   sat_val_type post, addr, divr;
   div_word_type feed;
   div_word_type chain_w [NumCells];

   // configuration port
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'(beta_ff) : 32'(alpha_ff);

   // shared multiplier and divider ring
   jpe_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .mul_req(mul_req),
      .mul_rsp(mul_rsp)
   );

   always_comb begin
      feed = chain_w[NumCells-1];
      if (div_cnt_ff == DivCntW'(0)) begin
         feed.rem = '0;
         feed.dq = {mag64(num_ff), 32'b0};
      end else if (div_cnt_ff == DivCntW'(1)) begin
         feed.rem = '0;
         feed.dq = {mag64(a4_ff), 32'b0};
      end
   end

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      jpe_div_cell u_cell (
         .clock   (clock),
         .word_in ((k == 0) ? feed : chain_w[(k == 0) ? 0 : k - 1]),
         .den     (den_ff),
         .word_out(chain_w[k])
      );
   end

   // saturating post steps
   always_comb begin
      logic [6:0] sh;
      logic [127:0] shifted;
      logic [63:0] m;
      logic signed [63:0] ea, eb;
      logic signed [64:0] s65;
      logic [DivSteps-1:0] q;
      logic dneg;
      sh = (state_ff == ST_MULX_W) ? 7'd30 : ((state_ff == ST_DERIV_W) ? 7'd9 : 7'd32);
      shifted = mul_rsp.mag >> sh;
      m = shifted[63:0];
      post.sat = (|shifted[127:64]) | m[63];
      if (post.sat) begin
         m = 64'(ValMax);
      end
      post.val = mul_rsp.neg ? -$signed(m) : $signed(m);

      if (state_ff == ST_UPDATE) begin
         ea = r1_ff;
         eb = -r2_ff;
      end else begin
         ea = a2_ff;
         eb = rx_ff;
      end
      s65 = 65'(ea) + 65'(eb);
      addr.sat = 1'b0;
      addr.val = s65[63:0];
      if (s65 > Lim) begin
         addr.sat = 1'b1;
         addr.val = ValMax;
      end else if (s65 < -Lim) begin
         addr.sat = 1'b1;
         addr.val = -ValMax;
      end

      q = chain_w[NumCells-1].dq;
      dneg = (div_cnt_ff == DivCntW'(DivSteps)) ? neg1_ff : neg2_ff;
      divr.sat = (|q[DivSteps-1:64]) | q[63];
      m = divr.sat ? 64'(ValMax) : q[63:0];
      divr.val = dneg ? -$signed(m) : $signed(m);
   end

   assign n_sel = (int'(req_order) > MaxOrder) ? NW'(MaxOrder) : NW'(req_order);

   // sequencer
   always_comb begin
      state_in = state_ff;
      sat_in = sat_ff;
      err_in = err_ff;
      rsp_valid_in = 1'b0;
      div_cnt_in = '0;
      mul_req.start = 1'b0;
      mul_req.a = a3_ff;
      mul_req.b = 64'(x_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sat_in = 1'b0;
               err_in = 1'b0;
               state_in = (req_op && n_sel == '0) ? ST_FINISH : ST_P1A;
            end
         end
         ST_P1A: state_in = ST_P1B;
         ST_P1B: state_in = ST_CHECK;
         ST_CHECK: begin
            if (ne_ff < NW'(2)) begin
               state_in = op_ff ? ST_DERIV : ST_FINISH;
            end else if (am_ff <= -16'sd256 || bm_ff <= -16'sd256) begin
               err_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_COEF0;
            end
         end
         ST_COEF0: state_in = ST_COEF1;
         ST_COEF1: state_in = ST_COEF2;
         ST_COEF2: state_in = ST_MULX;
         ST_MULX: begin
            mul_req.start = 1'b1;
            state_in = ST_MULX_W;
         end
         ST_MULX_W: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | post.sat;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            sat_in = sat_ff | addr.sat;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff + DivCntW'(1);
            if (div_cnt_ff == DivCntW'(DivSteps)) begin
               sat_in = sat_ff | divr.sat;
            end
            if (div_cnt_ff == DivCntW'(DivSteps + 1)) begin
               sat_in = sat_ff | divr.sat;
               div_cnt_in = '0;
               state_in = ST_MULC1;
            end
         end
         ST_MULC1: begin
            mul_req.start = 1'b1;
            mul_req.a = c1_ff;
            mul_req.b = p1_ff;
            state_in = ST_MULC1_W;
         end
         ST_MULC1_W: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | post.sat;
               state_in = ST_MULC2;
            end
         end
         ST_MULC2: begin
            mul_req.start = 1'b1;
            mul_req.a = c2_ff;
            mul_req.b = p0_ff;
            state_in = ST_MULC2_W;
         end
         ST_MULC2_W: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | post.sat;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sat_in = sat_ff | addr.sat;
            if ((i_ff + NW'(1)) == ne_ff) begin
               state_in = op_ff ? ST_DERIV : ST_FINISH;
            end else begin
               state_in = ST_COEF0;
            end
         end
         ST_DERIV: begin
            mul_req.start = 1'b1;
            mul_req.a = 64'(s_ff) + 64'({ne_ff, 8'b0});
            mul_req.b = res_ff;
            state_in = ST_DERIV_W;
         end
         ST_DERIV_W: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | post.sat;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         alpha_ff <= '0;
         beta_ff <= '0;
         sat_ff <= 1'b0;
         err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         sat_ff <= sat_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff <= div_cnt_in;
         if (psel && penable && pwrite) begin
            if (paddr[2]) begin
               beta_ff <= pwdata[12:0];
            end else begin
               alpha_ff <= pwdata[12:0];
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      logic signed [16:0] s2;
      logic signed [63:0] sum;
      logic signed [CoefW-1:0] ii, t0;
      s2 = 17'(am_ff) + 17'(bm_ff) + 17'sd512;
      sum = (64'(am_ff - bm_ff) <<< 30) + 64'(prod_ff);
      ii = CoefW'({i_ff, 8'b0});
      t0 = (ii <<< 1) + CoefW'(s_ff);
      case (state_ff)
         ST_IDLE: begin
            op_ff <= req_op;
            x_ff <= req_point;
            ne_ff <= req_op ? n_sel - NW'(1) : n_sel;
            am_ff <= req_op ? 16'(alpha_ff) + 16'sd256 : 16'(alpha_ff);
            bm_ff <= req_op ? 16'(beta_ff) + 16'sd256 : 16'(beta_ff);
            res_ff <= '0;
         end
         ST_P1A: begin
            s_ff <= am_ff + bm_ff;
            prod_ff <= 49'(s2) * 49'(x_ff);
            asq_ff <= am_ff * am_ff;
            bsq_ff <= bm_ff * bm_ff;
            p0_ff <= OneQ24;
         end
         ST_P1B: begin
            p1_ff <= sum[63] ? -64'((-sum) >> 15) : (sum >>> 15);
            d_ff <= asq_ff - bsq_ff;
         end
         ST_CHECK: begin
            i_ff <= NW'(1);
            if (ne_ff == '0) begin
               res_ff <= p0_ff;
            end else if (ne_ff == NW'(1)) begin
               res_ff <= p1_ff;
            end else begin
               res_ff <= ValMax;
            end
         end
         ST_COEF0: begin
            t0_ff <= t0;
            t1_ff <= t0 + CoefW'(Q8One);
            t2_ff <= t0 + CoefW'(2 * Q8One);
            u_ff <= ii + CoefW'(s_ff) + CoefW'(Q8One);
            v1_ff <= ii + CoefW'(am_ff);
            v2_ff <= ii + CoefW'(bm_ff);
            i1_ff <= CoefW'({1'b0, i_ff}) + CoefW'(1);
         end
         ST_COEF1: begin
            m1_ff <= 32'(i1_ff) * 32'(u_ff);
            m2_ff <= 32'(t0_ff) * 32'(t1_ff);
            m3_ff <= 32'(v1_ff) * 32'(v2_ff);
            a2_ff <= 64'(56'(t1_ff) * 56'(d_ff));
         end
         ST_COEF2: begin
            a1_ff <= 64'(56'(m1_ff) * 56'(t0_ff)) <<< 9;
            a3_ff <= 64'(56'(m2_ff) * 56'(t2_ff));
            a4_ff <= 64'(56'(m3_ff) * 56'(t2_ff)) <<< 1;
         end
         ST_MULX_W: begin
            if (mul_rsp.done) begin
               rx_ff <= post.val;
            end
         end
         ST_NUM: begin
            num_ff <= addr.val;
            neg1_ff <= addr.val[63] ^ a1_ff[63];
            neg2_ff <= a4_ff[63] ^ a1_ff[63];
            den_ff <= mag64(a1_ff);
         end
         ST_DIV: begin
            if (div_cnt_ff == DivCntW'(DivSteps)) begin
               c1_ff <= divr.val;
            end
            if (div_cnt_ff == DivCntW'(DivSteps + 1)) begin
               c2_ff <= divr.val;
            end
         end
         ST_MULC1_W: begin
            if (mul_rsp.done) begin
               r1_ff <= post.val;
            end
         end
         ST_MULC2_W: begin
            if (mul_rsp.done) begin
               r2_ff <= post.val;
            end
         end
         ST_UPDATE: begin
            p0_ff <= p1_ff;
            p1_ff <= addr.val;
            res_ff <= addr.val;
            i_ff <= i_ff + NW'(1);
         end
         ST_DERIV_W: begin
            if (mul_rsp.done) begin
               res_ff <= post.val;
            end
         end
         ST_FINISH: begin
            rsp_value_ff <= err_ff ? ValMax : res_ff;
            rsp_status_ff <= err_ff ? StatusRange : (sat_ff ? StatusSat : StatusOk);
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   `JPE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `JPE_ASSERT_NEXT(a_finish_strobe, state_ff == ST_FINISH, rsp_valid && !busy)
   `JPE_ASSERT_IMPLY(a_range_max, rsp_valid && rsp_status == StatusRange, rsp_value == ValMax)
   `JPE_ASSERT_IMPLY(a_mul_in_wait, mul_rsp.done, state_ff == ST_MULX_W || state_ff == ST_MULC1_W || state_ff == ST_MULC2_W || state_ff == ST_DERIV_W)

endmodule

>>> hw/rtl/jpe_div_cell.sv
module jpe_div_cell (
   input  logic                 clock,
   input  jpe_pkg::div_word_type word_in,
   input  logic [63:0]          den,
   output jpe_pkg::div_word_type word_out
);
   import jpe_pkg::*;

   div_word_type word_ff;
   div_word_type word_in_step;
   logic [64:0] rem_sh;

   always_comb begin
      rem_sh = {word_in.rem[63:0], word_in.dq[DivSteps-1]};
      word_in_step.dq = {word_in.dq[DivSteps-2:0], 1'b0};
      word_in_step.rem = rem_sh;
      if (rem_sh >= {1'b0, den}) begin
         word_in_step.rem = rem_sh - {1'b0, den};
         word_in_step.dq[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in_step;
   end

   assign word_out = word_ff;

endmodule

>>> hw/rtl/jpe_mul.sv
module jpe_mul (
   input  logic                clock,
   input  logic                reset,
   input  jpe_pkg::mul_req_type mul_req,
   output jpe_pkg::mul_rsp_type mul_rsp
);
   import jpe_pkg::*;

   logic [63:0] ua_ff, ub_ff;
   logic neg_ff;
   logic [127:0] acc_ff;
   logic [63:0] pp_ff;
   logic [1:0] pidx_ff;
   logic [2:0] ph_ff, ph_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] a_part, b_part;
   logic [6:0] pp_sh;

   always_comb begin
      ph_in = ph_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         ph_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ph_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            ph_in = ph_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 3'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign a_part = ph_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_part = ph_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
   assign pp_sh = (pidx_ff == 2'd3) ? 7'd64 : ((pidx_ff == 2'd0) ? 7'd0 : 7'd32);

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         ua_ff <= mag64(mul_req.a);
         ub_ff <= mag64(mul_req.b);
         neg_ff <= mul_req.a[63] ^ mul_req.b[63];
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (ph_ff != 3'd4) begin
            pp_ff <= 64'(a_part) * 64'(b_part);
            pidx_ff <= ph_ff[1:0];
         end
         if (ph_ff != 3'd0) begin
            acc_ff <= acc_ff + ({64'b0, pp_ff} << pp_sh);
         end
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.neg = neg_ff;
   assign mul_rsp.mag = acc_ff;

endmodule

>>> test/tb_jacobi_polynomial_eval.sv
`timescale 1ns / 100ps

module tb_jacobi_polynomial_eval;
   import jpe_pkg::*;

   localparam logic OpValue = 1'b0;
   localparam logic OpDeriv = 1'b1;
   localparam logic [2:0] AddrAlpha = 3'd0;
   localparam logic [2:0] AddrBeta = 3'd4;
   localparam int StallLimit = 50000;
   localparam int TailCycles = 100;
   localparam int PhaseCount = 10;
   localparam int PhaseItems = 60;
   localparam int PosOne = 32'sh4000_0000;
   localparam int NegOne = -32'sh4000_0000;

   typedef struct {
      logic signed [63:0] value;
      logic [1:0] status;
   } jacobi_result_type;

   typedef struct {
      int alpha;
      int beta;
      bit op;
      int order;
      int point;
      bit typed;
      longint ev;
      int es;
   } dir_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_op;
   logic [5:0] req_order;
   logic signed [31:0] req_point;
   logic rsp_valid;
   logic signed [63:0] rsp_value;
   logic [1:0] rsp_status;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   logic signed [12:0] alpha_q;
   logic signed [12:0] beta_q;
   jacobi_result_type pending_q[$];
   int errors;
   int idle_cycles;
   int n_sent;
   int n_value;
   int n_deriv;
   int n_range;
   int n_sat;
   bit no_gaps;

   dir_row_type dir_table [0:21] = '{
      '{0, 0, OpValue, 0, 0, 1, 64'sh0100_0000, 0},
      '{0, 0, OpDeriv, 0, PosOne, 1, 0, 0},
      '{0, 0, OpValue, 1, PosOne, 1, 64'sh0100_0000, 0},
      '{0, 0, OpValue, 1, NegOne, 1, -64'sh0100_0000, 0},
      '{0, 0, OpDeriv, 1, 12345, 1, 64'sh0100_0000, 0},
      '{0, 0, OpValue, 2, 0, 0, 0, 0},
      '{0, 0, OpValue, 32, PosOne, 0, 0, 0},
      '{0, 0, OpValue, 63, NegOne, 0, 0, 0},
      '{0, 0, OpDeriv, 32, PosOne, 0, 0, 0},
      '{0, 0, OpValue, 4, 32'sh7FFF_FFFF, 0, 0, 0},
      '{0, 0, OpValue, 4, 32'sh8000_0000, 0, 0, 0},
      '{-256, 0, OpValue, 2, 0, 1, 64'sh7FFF_FFFF_FFFF_FFFF, 1},
      '{0, -256, OpValue, 5, PosOne, 1, 64'sh7FFF_FFFF_FFFF_FFFF, 1},
      '{-512, 0, OpDeriv, 2, 5000000, 0, 0, 0},
      '{-512, 0, OpDeriv, 3, 5000000, 1, 64'sh7FFF_FFFF_FFFF_FFFF, 1},
      '{-1024, -1024, OpValue, 1, NegOne, 0, 0, 0},
      '{-1024, -1024, OpDeriv, 1, PosOne, 0, 0, 0},
      '{4095, 4095, OpValue, 32, PosOne, 0, 0, 0},
      '{4095, 4095, OpDeriv, 32, NegOne, 0, 0, 0},
      '{4095, -1024, OpValue, 8, 0, 1, 64'sh7FFF_FFFF_FFFF_FFFF, 1},
      '{2047, 100, OpDeriv, 10, 32'sh1234_5678, 0, 0, 0},
      '{-255, -255, OpValue, 6, -32'sh2000_0000, 0, 0, 0}
   };

   jacobi_polynomial_eval i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_order(req_order),
      .req_point(req_point),
      .rsp_valid(rsp_valid),
      .rsp_value(rsp_value),
      .rsp_status(rsp_status),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] abs64(input longint v);
      logic [63:0] r;
      r = v;
      if (v < 0) r = -r;
      return r;
   endfunction

   function automatic longint clip64(input logic [63:0] m, input bit neg, inout bit sat);
      logic [63:0] r;
      r = m;
      if (r > 64'h7FFF_FFFF_FFFF_FFFF) begin
         r = 64'h7FFF_FFFF_FFFF_FFFF;
         sat = 1'b1;
      end
      return neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic longint add_clip(input longint a, input longint b, inout bit sat);
      longint top;
      top = ValMax;
      if (b > 0 && a > top - b) begin
         sat = 1'b1;
         return top;
      end
      if (b < 0 && a < -top - b) begin
         sat = 1'b1;
         return -top;
      end
      return a + b;
   endfunction

   function automatic longint mul_scaled(input longint a, input longint b, input int sh,
                                         inout bit sat);
      logic [127:0] pr;
      logic [63:0] m;
      pr = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      pr = pr >> sh;
      if (pr[127:64] != 0) begin
         sat = 1'b1;
         m = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         m = pr[63:0];
      end
      return clip64(m, (a < 0) != (b < 0), sat);
   endfunction

   function automatic longint div_scaled(input longint num, input longint den, input int sh,
                                         inout bit sat);
      logic [127:0] q;
      logic [63:0] m;
      bit neg;
      neg = (num < 0) != (den < 0);
      if (den == 0) return clip64({64{1'b1}}, neg, sat);
      q = ({64'd0, abs64(num)} << sh) / {64'd0, abs64(den)};
      m = (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
      return clip64(m, neg, sat);
   endfunction

   function automatic longint jacobi_value(input longint am, input longint bm, input int n,
                                           input longint x, inout bit err, inout bit sat);
      longint s, p0, p1, pn, ii, t0, t1, t2, a1, a2, a3, a4, num, c1, c2;
      s = am + bm;
      p0 = OneQ24;
      p1 = ((am - bm) * (64'sd1 <<< 30) + (s + 2 * Q8One) * x) / 32768;
      if (n == 0) return p0;
      if (n == 1) return p1;
      if (am <= -Q8One || bm <= -Q8One) begin
         err = 1'b1;
         return ValMax;
      end
      for (int i = 1; i < n; i++) begin
         ii = i * Q8One;
         t0 = 2 * ii + s;
         t1 = t0 + Q8One;
         t2 = t0 + 2 * Q8One;
         a1 = 2 * longint'(i + 1) * (ii + s + Q8One) * t0 * Q8One;
         a2 = t1 * (am * am - bm * bm);
         a3 = t0 * t1 * t2;
         a4 = 2 * (ii + am) * (ii + bm) * t2;
         num = add_clip(a2, mul_scaled(a3, x, 30, sat), sat);
         c1 = div_scaled(num, a1, 32, sat);
         c2 = div_scaled(a4, a1, 32, sat);
         pn = add_clip(mul_scaled(c1, p1, 32, sat), -mul_scaled(c2, p0, 32, sat), sat);
         p0 = p1;
         p1 = pn;
      end
      return p1;
   endfunction

   function automatic jacobi_result_type predict_result(input logic op,
                                                        input logic [5:0] order,
                                                        input logic signed [31:0] point);
      jacobi_result_type r;
      longint am, bm, x, p, v;
      int n;
      bit err, sat;
      am = alpha_q;
      bm = beta_q;
      x = point;
      n = (order > MaxOrderDefault) ? MaxOrderDefault : order;
      err = 1'b0;
      sat = 1'b0;
      if (op == OpValue) begin
         v = jacobi_value(am, bm, n, x, err, sat);
      end else if (n == 0) begin
         v = 0;
      end else begin
         p = jacobi_value(am + Q8One, bm + Q8One, n - 1, x, err, sat);
         if (err) v = ValMax;
         else v = mul_scaled(am + bm + longint'(n + 1) * Q8One, p, 9, sat);
      end
      r.value = v;
      r.status = err ? StatusRange : (sat ? StatusSat : StatusOk);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rd);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      rd = prdata;
      idle_cycles = 0;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic apply_config(input logic signed [12:0] a, input logic signed [12:0] b);
      logic [31:0] rd;
      @(negedge clock);
      start = 1'b0;
      wait (pending_q.size() == 0 && !busy);
      repeat (4) @(negedge clock);
      csr_access(1'b1, AddrAlpha, {$urandom_range(0, 1) ? 19'($urandom) : 19'd0, a}, rd);
      csr_access(1'b1, AddrBeta, {$urandom_range(0, 1) ? 19'($urandom) : 19'd0, b}, rd);
      alpha_q = a;
      beta_q = b;
      csr_access(1'b0, AddrAlpha, 32'd0, rd);
      if (rd[12:0] != a) report_mismatch($sformatf("alpha readback %h", rd[12:0]));
      csr_access(1'b0, AddrBeta, 32'd0, rd);
      if (rd[12:0] != b) report_mismatch($sformatf("beta readback %h", rd[12:0]));
   endtask

   function automatic int pick_gap();
      if (no_gaps) return 0;
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
   endfunction

   task automatic send_request(input logic op, input logic [5:0] order,
                               input logic signed [31:0] point, input bit typed,
                               input jacobi_result_type typed_exp);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      while (busy) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_op = op;
      req_order = order;
      req_point = point;
      @(posedge clock);
      pending_q.push_back(typed ? typed_exp : predict_result(op, order, point));
      idle_cycles = 0;
      n_sent++;
   endtask

   function automatic logic signed [12:0] pick_param();
      case ($urandom_range(0, 7))
         0: return -13'sd1024;
         1: return 13'sd4095;
         2: return 13'sd0;
         3: return -13'sd256;
         4: return 13'($urandom);
         default: return 13'($urandom_range(0, 5119) - 1024);
      endcase
   endfunction

   function automatic logic [5:0] pick_order();
      if ($urandom_range(0, 9) == 0) return 6'($urandom);
      return 6'($urandom_range(0, 8));
   endfunction

   function automatic logic signed [31:0] pick_point();
      case ($urandom_range(0, 9))
         0: return PosOne;
         1: return NegOne;
         2: return 32'($urandom);
         default: return $urandom_range(0, 32'h8000_0000) - 32'sh4000_0000;
      endcase
   endfunction

   always @(posedge clock) begin
      jacobi_result_type e;
      if (!reset && rsp_valid) begin
         idle_cycles = 0;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h/%0d", rsp_value, rsp_status));
         end else begin
            e = pending_q.pop_front();
            if (rsp_value !== e.value)
               report_mismatch($sformatf("value %h, want %h", rsp_value, e.value));
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, e.status));
            if (e.status == StatusRange) n_range++;
            if (e.status == StatusSat) n_sat++;
         end
      end
   end

   always @(posedge clock) begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("watchdog: no progress for %0d cycles", StallLimit);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      jacobi_result_type te;
      logic op;
      errors = 0;
      idle_cycles = 0;
      n_sent = 0;
      n_value = 0;
      n_deriv = 0;
      n_range = 0;
      n_sat = 0;
      no_gaps = 1'b0;
      alpha_q = '0;
      beta_q = '0;
      reset = 1'b1;
      start = 1'b0;
      req_op = OpValue;
      req_order = '0;
      req_point = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[k]) begin
         if (dir_table[k].alpha != alpha_q || dir_table[k].beta != beta_q)
            apply_config(13'(dir_table[k].alpha), 13'(dir_table[k].beta));
         te.value = dir_table[k].ev;
         te.status = 2'(dir_table[k].es);
         if (dir_table[k].op == OpValue) n_value++;
         else n_deriv++;
         send_request(dir_table[k].op, 6'(dir_table[k].order), dir_table[k].point,
                      dir_table[k].typed, te);
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         @(negedge clock);
         start = 1'b0;
         apply_config(pick_param(), pick_param());
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PhaseItems; k++) begin
            op = 1'($urandom);
            if (op == OpValue) n_value++;
            else n_deriv++;
            send_request(op, pick_order(), pick_point(), 1'b0, te);
         end
      end
      @(negedge clock);
      start = 1'b0;

      wait (pending_q.size() == 0);
      repeat (TailCycles) @(posedge clock);
      $display("covered %0d requests (%0d value, %0d derivative) over %0d parameter sets",
               n_sent, n_value, n_deriv, PhaseCount);
      $display("range errors seen %0d, saturations seen %0d, mismatches %0d",
               n_range, n_sat, errors);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/jpe_pkg.sv
hw/rtl/jpe_div_cell.sv
hw/rtl/jpe_mul.sv
hw/rtl/jacobi_polynomial_eval.sv
test/tb_jacobi_polynomial_eval.sv
